>>> src/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and the bytewise CRC-16 update for the reply deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  localparam logic [7:0]  START_BYTE_RESET = 8'hF2;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_TOP          = 16'h8000;
  localparam logic [15:0] CRC_INIT         = 16'h0000;

  // Input function codes
  typedef enum logic {
    FUNC_BYTE    = 1'b0,
    FUNC_TIMEOUT = 1'b1
  } rfd_func_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } rfd_kind_t;

  // Frame phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_CRC_HI = 6'b010000,
    PH_CRC_LO = 6'b100000
  } rfd_phase_t;

  // One input word as held in the input register
  typedef struct packed {
    rfd_func_t  func;
    logic [7:0] rx_byte;
  } rfd_item_t;

  // One result word
  typedef struct packed {
    rfd_kind_t  kind;
    logic [7:0] value;
  } rfd_result_t;

  // CRC-16, MSB first, one byte folded in over eight bit steps
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [15:0] d;
    c = crc;
    d = {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (((c ^ d) & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
      d = {d[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/rfd_in_stage.sv
// ----------------------------------------------------------------------------
// rfd_in_stage
// Input register: captures one word per cycle unless stalled, holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               take,
  output logic                    item_valid,
  output rfd_pkg::rfd_item_t      item
);
  import rfd_pkg::*;

  logic      item_valid_r;
  rfd_item_t item_r;
  logic      load;

  // Refill when empty or when the held word leaves this cycle
  assign load     = !item_valid_r || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (load) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r.func    <= rfd_func_t'(in_func);
      item_r.rx_byte <= in_rx_byte;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

>>> src/rfd_core.sv
// ----------------------------------------------------------------------------
// rfd_core
// Frame state machine, running CRC and result generation for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          start_byte,
  input  wire logic                item_valid,
  input  wire rfd_pkg::rfd_item_t  item,
  input  wire logic                out_free,
  output logic                     take,
  output logic                     res_valid,
  output rfd_pkg::rfd_result_t     res
);
  import rfd_pkg::*;

  rfd_phase_t  phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  payload_count_r, payload_count_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  crc_high_r, crc_high_nxt;
  logic [15:0] crc_step;
  logic [7:0]  left_dec;

  assign take     = item_valid && out_free;
  assign crc_step = crc_add(running_crc_r, item.rx_byte);
  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    bytes_left_nxt    = bytes_left_r;
    payload_count_nxt = payload_count_r;
    running_crc_nxt   = running_crc_r;
    crc_high_nxt      = crc_high_r;
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.value         = item.rx_byte;

    if (item.func == FUNC_TIMEOUT) begin
      // Abort a frame in progress; ignore while hunting
      case (phase_r)
        PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CRC_HI, PH_CRC_LO: begin
          res_valid = 1'b1;
          res.kind  = KIND_TIMEOUT;
          res.value = payload_count_r;
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end else begin
      case (phase_r)
        PH_LEN_HI: begin
          running_crc_nxt = crc_step;
          phase_nxt       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          running_crc_nxt   = crc_step;
          payload_count_nxt = item.rx_byte;
          bytes_left_nxt    = item.rx_byte;
          phase_nxt         = (item.rx_byte == 8'd0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          running_crc_nxt = crc_step;
          bytes_left_nxt  = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_CRC_HI;
          end
          res_valid = 1'b1;
          res.kind  = KIND_PAYLOAD;
          res.value = item.rx_byte;
        end
        PH_CRC_HI: begin
          crc_high_nxt = item.rx_byte;
          phase_nxt    = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          res_valid = 1'b1;
          res.kind  = ({crc_high_r, item.rx_byte} == running_crc_r) ? KIND_GOOD
                                                                    : KIND_CRC_ERR;
          res.value = payload_count_r;
          phase_nxt = PH_HUNT;
        end
        default: begin
          // Hunt: drop everything but the start byte
          phase_nxt = PH_HUNT;
          if (item.rx_byte == start_byte) begin
            running_crc_nxt   = crc_add(CRC_INIT, item.rx_byte);
            payload_count_nxt = 8'd0;
            bytes_left_nxt    = 8'd0;
            crc_high_nxt      = 8'd0;
            phase_nxt         = PH_LEN_HI;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      bytes_left_r    <= 8'd0;
      payload_count_r <= 8'd0;
      running_crc_r   <= CRC_INIT;
      crc_high_r      <= 8'd0;
    end else if (take) begin
      phase_r         <= phase_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_count_r <= payload_count_nxt;
      running_crc_r   <= running_crc_nxt;
      crc_high_r      <= crc_high_nxt;
    end
  end

  // A verdict always returns the machine to hunting
  a_verdict_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid && res.kind != KIND_PAYLOAD |=> phase_r == PH_HUNT)
    else $error("verdict did not return to hunt");

  // Payload words only come out of the data phase
  a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid && res.kind == KIND_PAYLOAD |-> phase_r == PH_DATA)
    else $error("payload word outside data phase");

  // Low length byte loads count and remaining length alike
  a_len_load: assert property (@(posedge clk) disable iff (!rst_n)
    take && item.func == FUNC_BYTE && phase_r == PH_LEN_LO
    |=> payload_count_r == bytes_left_r)
    else $error("length load mismatch");

  // Data phase is never entered with nothing left to pass
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_left_r != 8'd0)
    else $error("data phase with zero bytes left");

endmodule

`default_nettype wire

>>> src/reply_frame_deframer_crc16_unit.sv
// ----------------------------------------------------------------------------
// reply_frame_deframer_crc16_unit
// Deframes start/length/payload/CRC-16 reply frames from a serial byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per received serial event.
//   in_func = 0 carries a received byte in in_rx_byte; in_func = 1 reports a
//   read timeout (in_rx_byte ignored).
//   Result channel (out_valid / out_stall): out_kind 0 passes a payload byte
//   in out_value; kinds 1 (good), 2 (CRC error), 3 (timeout abort) close the
//   frame and carry the payload count in out_value. Not every word gives a result.
//   cfg_wr_en / cfg_wr_data write the start byte; write only while idle.
// Timing:
//   A word accepted into the input register is processed by the state machine
//   and CRC logic once the core takes it, and its result is then registered in
//   the result register. Throughput is one word per cycle while the result
//   register is free (out_stall low or no result waiting); the one-byte CRC
//   update lies between the input and result registers.
// Reset:
//   rst_n (synchronous, active low) empties both registers, returns to hunting
//   for the start byte and loads the start byte with 0xF2.
// Backpressure:
//   While out_stall holds a waiting result, the result register holds; the
//   input register then fills and in_stall rises until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_frame_deframer_crc16_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_value
);
  import rfd_pkg::*;

  logic        [7:0] start_byte_r;
  logic              item_valid;
  rfd_item_t         item;
  logic              take;
  logic              res_valid;
  rfd_result_t       res;
  logic              out_free;
  logic              out_valid_r;
  rfd_result_t       out_r;

  // Start byte register; a change takes effect at the next hunt
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RESET;
    end else if (cfg_wr_en) begin
      start_byte_r <= cfg_wr_data;
    end
  end

  // Input register
  rfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Frame logic
  rfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_byte (start_byte_r),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register: load on a processed word, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_r.kind;
  assign out_value = out_r.value;

endmodule

`default_nettype wire

>>> tb/sv/reply_frame_deframer_crc16_unit_test.sv
// ----------------------------------------------------------------------------
// reply_frame_deframer_crc16_unit_test
// Self-checking bench for the reply frame deframer. Streams noise, well-formed
// frames, frames with a corrupted CRC and frames cut short by a read timeout
// under several start byte values. Every accepted input word is run through a
// frame predictor with its own CRC-16; each result word is checked against the
// oldest predicted result.
// ----------------------------------------------------------------------------

module reply_frame_deframer_crc16_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rfd_pkg::*;

  // Frame predictor plus the queue of results it still owes.
  class deframe_scoreboard;
    logic [7:0]  start_byte;
    rfd_phase_t  phase;
    logic [7:0]  bytes_left;
    logic [7:0]  payload_count;
    logic [15:0] running_crc;
    logic [7:0]  crc_high;
    rfd_result_t owed_q[$];
    int          errors;

    function new();
      start_byte    = START_BYTE_RESET;
      phase         = PH_HUNT;
      bytes_left    = '0;
      payload_count = '0;
      running_crc   = CRC_INIT;
      crc_high      = '0;
      errors        = 0;
    endfunction

    // CRC-16, polynomial 0x1021, MSB first, one byte per call.
    static function logic [15:0] fold_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] acc;
      bit          fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
        fb  = acc[15] ^ b[i];
        acc = {acc[14:0], 1'b0};
        if (fb) acc = acc ^ CRC_POLY;
      end
      return acc;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the frame state by one accepted word.
    function void note_word(rfd_func_t f, logic [7:0] b);
      if (f == FUNC_TIMEOUT) begin
        if (phase != PH_HUNT) begin
          owed_q.push_back(rfd_result_t'{kind: KIND_TIMEOUT, value: payload_count});
        end
        phase = PH_HUNT;
        return;
      end
      case (phase)
        PH_LEN_HI: begin
          running_crc = fold_byte(running_crc, b);
          phase       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          running_crc   = fold_byte(running_crc, b);
          payload_count = b;
          bytes_left    = b;
          phase         = (b == 8'd0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          running_crc = fold_byte(running_crc, b);
          bytes_left  = bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = PH_CRC_HI;
          owed_q.push_back(rfd_result_t'{kind: KIND_PAYLOAD, value: b});
        end
        PH_CRC_HI: begin
          crc_high = b;
          phase    = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          owed_q.push_back(rfd_result_t'{
            kind:  ({crc_high, b} == running_crc) ? KIND_GOOD : KIND_CRC_ERR,
            value: payload_count});
          phase = PH_HUNT;
        end
        default: begin
          if (b == start_byte) begin
            running_crc   = fold_byte(CRC_INIT, b);
            payload_count = '0;
            bytes_left    = '0;
            crc_high      = '0;
            phase         = PH_LEN_HI;
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] value);
      rfd_result_t exp_r;
      if (owed_q.size() == 0) begin
        $error("result with nothing expected: kind %0d value %0d", kind, value);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind: expected %0d, got %0d", exp_r.kind, kind);
        errors++;
      end
      if (value !== exp_r.value) begin
        $error("value: expected %0d, got %0d", exp_r.value, value);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_func;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_value;

  deframe_scoreboard sb;
  int  words_sent;
  // quiet turns off idling on both sides; hold_len asks the receiver to stall
  bit  quiet;
  int  hold_len;

  reply_frame_deframer_crc16_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Track accepted input words and check accepted result words at the edge
  // where the handshake completes; all drives move on the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(rfd_func_t'(in_func), in_rx_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_kind, out_value);
  end

  // Receiver: random short stalls, or one long hold-off when asked. The
  // hold-off is counted here so the sender keeps pushing words meanwhile.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  // Offer one word and hold it until taken. Called and returns on a falling
  // edge; valid stays high into the next word unless a gap is rolled.
  task automatic send_word(input rfd_func_t f, input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= f;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Send one frame under the current start byte. abort_at names the word
  // position (0 = start byte) replaced by a read timeout, or -1 for none.
  task automatic send_frame(input logic [7:0] len_hi, input logic [7:0] len,
                            input bit bad_crc, input int abort_at,
                            input bit start_fill);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    logic [7:0]  b;
    frame_q.push_back(sb.start_byte);
    frame_q.push_back(len_hi);
    frame_q.push_back(len);
    for (int i = 0; i < len; i++) begin
      // mix in the start byte value so it shows up as ordinary frame data
      if (start_fill || $urandom_range(7) == 0) b = sb.start_byte;
      else b = 8'($urandom_range(255));
      frame_q.push_back(b);
    end
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = deframe_scoreboard::fold_byte(crc, frame_q[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == abort_at) begin
        send_word(FUNC_TIMEOUT, 8'($urandom_range(255)));
        break;
      end
      send_word(FUNC_BYTE, frame_q[i]);
    end
  endtask

  // Drop valid, wait until every owed result is in, then let the last word
  // (which may owe nothing) clear the two register stages.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.start_byte = v;
  endtask

  // Mostly well-formed frames with random content, some corrupted, some cut
  // by a timeout, with noise words between them.
  task automatic run_random(input int target);
    int base;
    int r;
    int len;
    base = words_sent;
    while (words_sent - base < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_word(rfd_func_t'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        len = ($urandom_range(49) == 0) ? $urandom_range(128, 255) : $urandom_range(12);
        send_frame(8'($urandom_range(255)), 8'(len), $urandom_range(99) < 20,
                   (r < 16) ? int'($urandom_range(len + 4)) : -1, 1'b0);
      end
    end
    // close any frame a noise byte may have opened
    send_word(FUNC_TIMEOUT, 8'($urandom_range(255)));
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_func     = 1'b0;
    in_rx_byte  = '0;
    words_sent  = 0;
    quiet       = 1'b0;
    hold_len    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset start byte
    send_word(FUNC_TIMEOUT, 8'hFF);           // timeout while hunting: nothing
    send_word(FUNC_BYTE, 8'h00);              // noise: dropped
    send_frame(8'hFF, 8'd0, 1'b0, -1, 1'b0);  // empty payload, good
    send_frame(8'h00, 8'd2, 1'b1, -1, 1'b1);  // start byte as data, bad CRC
    send_frame(8'h00, 8'd0, 1'b0, 1, 1'b0);   // timeout before high length
    send_frame(8'h01, 8'd0, 1'b0, 2, 1'b0);   // timeout before low length
    send_frame(8'h00, 8'd3, 1'b0, 4, 1'b0);   // timeout inside payload
    run_random(240);

    write_start_byte(8'h00);
    run_random(240);

    // no idling on either side through this phase
    write_start_byte(8'hFF);
    quiet = 1'b1;
    run_random(240);
    quiet = 1'b0;

    write_start_byte(8'($urandom_range(255)));
    send_frame(8'($urandom_range(255)), 8'd255, 1'b0, -1, 1'b0);
    // hold the receiver off while a long frame keeps coming
    hold_len = 80;
    send_frame(8'($urandom_range(255)), 8'd60, 1'b0, -1, 1'b0);
    run_random(240);

    settle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> reply_frame_deframer_crc16_unit.f
src/rfd_pkg.sv
src/rfd_in_stage.sv
src/rfd_core.sv
src/reply_frame_deframer_crc16_unit.sv
tb/sv/reply_frame_deframer_crc16_unit_test.sv
